[hw/rtl/threshold_region_growing_macros.svh]
// Assertion macros for the region growing block.
// Used by the port checker; depends on clock and reset in the including scope.
`ifndef THRESHOLD_REGION_GROWING_MACROS_SVH
`define THRESHOLD_REGION_GROWING_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TRG_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TRG_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/trg_pkg.sv]
// Shared constants, codes and types for the region growing block.
// No dependencies; imported by every module of the block.
package trg_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int ADDR_W     = COL_W + ROW_W;
   localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
   localparam int CNT_W      = ADDR_W + 1;
   localparam int SIZE_W     = 9;
   localparam int COORD_W    = 8;
   localparam int THR_W      = 9;
   localparam int PIX_W      = 8;
   localparam int LBL_W      = 2;
   localparam int CMD_W      = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GROW = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   localparam logic [LBL_W-1:0] LBL_FREE = 2'd0;
   localparam logic [LBL_W-1:0] LBL_IN   = 2'd1;
   localparam logic [LBL_W-1:0] LBL_OUT  = 2'd2;

   localparam logic [1:0] DIR_LEFT  = 2'd0;
   localparam logic [1:0] DIR_DOWN  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;
   localparam logic [1:0] DIR_UP    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEED_X    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SEED_Y    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd4;

   typedef struct packed {
      logic [SIZE_W-1:0]  width;
      logic [SIZE_W-1:0]  height;
      logic [COORD_W-1:0] seed_x;
      logic [COORD_W-1:0] seed_y;
      logic [THR_W-1:0]   threshold;
   } cfg_type;

   typedef struct packed {
      logic              clear;
      logic              push;
      logic              pop;
      logic [ADDR_W-1:0] wdata;
   } q_ctrl_type;

   typedef struct packed {
      logic              empty;
      logic [ADDR_W-1:0] rdata;
   } q_stat_type;

endpackage

[hw/rtl/trg_queue.sv]
// Frontier FIFO of pixel addresses held in a synchronous memory.
// Depends on trg_pkg for widths and the control and status structs.
module trg_queue
   import trg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_ctrl_type ctrl,
   output q_stat_type stat
);

   logic [ADDR_W-1:0] q_mem [DEPTH];
   logic [ADDR_W-1:0] rdata_ff;
   logic [CNT_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  tail_ff, tail_in;
   logic              push_ok;

   assign push_ok = ctrl.push && (tail_ff < CNT_W'(DEPTH));

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctrl.clear) begin
         head_in = '0;
         tail_in = '0;
      end else begin
         if (ctrl.pop) begin
            head_in = head_ff + CNT_W'(1);
         end
         if (push_ok) begin
            tail_in = tail_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok && !ctrl.clear) begin
         q_mem[tail_ff[ADDR_W-1:0]] <= ctrl.wdata;
      end
      if (ctrl.pop) begin
         rdata_ff <= q_mem[head_ff[ADDR_W-1:0]];
      end
   end

   assign stat.empty = (head_ff == tail_ff);
   assign stat.rdata = rdata_ff;

endmodule

[hw/rtl/trg_engine.sv]
// Command sequencer with the pixel and label memories and the result register.
// Depends on trg_pkg; drives the frontier FIFO through q_ctrl_type.
module trg_engine
   import trg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [ADDR_W-1:0] req_pixel_index,
   input  logic [PIX_W-1:0]  req_pixel_value,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [LBL_W-1:0]  rsp_label,
   output logic              rsp_done_res,
   output q_ctrl_type        q_ctrl,
   input  q_stat_type        q_stat
);

   localparam logic [3:0] S_INIT  = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_READ  = 4'd2;
   localparam logic [3:0] S_GCLR  = 4'd3;
   localparam logic [3:0] S_GSEED = 4'd4;
   localparam logic [3:0] S_DEQ   = 4'd5;
   localparam logic [3:0] S_CUR   = 4'd6;
   localparam logic [3:0] S_PIX   = 4'd7;
   localparam logic [3:0] S_NB    = 4'd8;
   localparam logic [3:0] S_EVAL  = 4'd9;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [ADDR_W-1:0] cur_ff, cur_in;
   logic [ADDR_W-1:0] nb_ff, nb_in;
   logic [PIX_W-1:0]  cur_pix_ff, cur_pix_in;
   logic [1:0]        dir_ff, dir_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LBL_W-1:0]  rsp_label_ff, rsp_label_in;
   logic              rsp_done_ff, rsp_done_in;

   logic [PIX_W-1:0]  pix_mem [DEPTH];
   logic [LBL_W-1:0]  lbl_mem [DEPTH];
   logic [PIX_W-1:0]  pix_rdata_ff;
   logic [LBL_W-1:0]  lbl_rdata_ff;

   logic              pix_we, pix_re, lbl_we, lbl_re;
   logic [ADDR_W-1:0] pix_raddr, lbl_waddr, lbl_raddr;
   logic [LBL_W-1:0]  lbl_wdata;

   logic              rsp_set;
   logic [LBL_W-1:0]  rsp_set_label;
   logic              rsp_set_done;

   logic [SIZE_W-1:0] w_eff, h_eff;
   logic              seed_out;
   logic [ADDR_W-1:0] seed_addr;
   logic [COL_W-1:0]  col;
   logic [ROW_W-1:0]  row;
   logic              nb_ok;
   logic [ADDR_W-1:0] nb_addr;
   logic [PIX_W-1:0]  diff;
   logic              accept_nb;
   logic              req_fire;

   always_comb begin
      if (cfg.width == '0) begin
         w_eff = SIZE_W'(1);
      end else if (cfg.width > SIZE_W'(MAX_WIDTH)) begin
         w_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         w_eff = cfg.width;
      end
      if (cfg.height == '0) begin
         h_eff = SIZE_W'(1);
      end else if (cfg.height > SIZE_W'(MAX_HEIGHT)) begin
         h_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         h_eff = cfg.height;
      end
   end

   assign seed_out  = ({1'b0, cfg.seed_x} >= w_eff) || ({1'b0, cfg.seed_y} >= h_eff);
   assign seed_addr = {cfg.seed_y[ROW_W-1:0], cfg.seed_x[COL_W-1:0]};

   assign col = cur_ff[COL_W-1:0];
   assign row = cur_ff[ADDR_W-1:COL_W];

   always_comb begin
      case (dir_ff)
         DIR_LEFT: begin
            nb_ok   = (col != '0);
            nb_addr = cur_ff - ADDR_W'(1);
         end
         DIR_DOWN: begin
            nb_ok   = ((SIZE_W'(row) + SIZE_W'(1)) < h_eff);
            nb_addr = cur_ff + ADDR_W'(MAX_WIDTH);
         end
         DIR_RIGHT: begin
            nb_ok   = ((SIZE_W'(col) + SIZE_W'(1)) < w_eff);
            nb_addr = cur_ff + ADDR_W'(1);
         end
         default: begin
            nb_ok   = (row != '0);
            nb_addr = cur_ff - ADDR_W'(MAX_WIDTH);
         end
      endcase
   end

   assign diff = (cur_pix_ff > pix_rdata_ff) ? (cur_pix_ff - pix_rdata_ff)
                                             : (pix_rdata_ff - cur_pix_ff);
   assign accept_nb = ({1'b0, diff} < cfg.threshold);

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      nb_in         = nb_ff;
      cur_pix_in    = cur_pix_ff;
      dir_in        = dir_ff;
      pix_we        = 1'b0;
      pix_re        = 1'b0;
      pix_raddr     = nb_addr;
      lbl_we        = 1'b0;
      lbl_re        = 1'b0;
      lbl_waddr     = nb_ff;
      lbl_wdata     = LBL_FREE;
      lbl_raddr     = nb_addr;
      rsp_set       = 1'b0;
      rsp_set_label = LBL_FREE;
      rsp_set_done  = 1'b1;
      q_ctrl        = '0;
      q_ctrl.wdata  = nb_ff;

      case (state_ff)
         S_INIT, S_GCLR: begin
            lbl_we    = 1'b1;
            lbl_waddr = clr_ff;
            lbl_wdata = LBL_FREE;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_GSEED;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               case (req_command)
                  CMD_LOAD: begin
                     pix_we  = 1'b1;
                     rsp_set = 1'b1;
                  end
                  CMD_GROW: begin
                     q_ctrl.clear = 1'b1;
                     clr_in       = '0;
                     state_in     = S_GCLR;
                  end
                  CMD_READ: begin
                     lbl_re    = 1'b1;
                     lbl_raddr = req_pixel_index;
                     state_in  = S_READ;
                  end
                  default: begin
                     rsp_set      = 1'b1;
                     rsp_set_done = 1'b0;
                  end
               endcase
            end
         end
         S_READ: begin
            rsp_set       = 1'b1;
            rsp_set_label = lbl_rdata_ff;
            state_in      = S_IDLE;
         end
         S_GSEED: begin
            if (seed_out) begin
               rsp_set  = 1'b1;
               state_in = S_IDLE;
            end else begin
               lbl_we       = 1'b1;
               lbl_waddr    = seed_addr;
               lbl_wdata    = LBL_IN;
               q_ctrl.push  = 1'b1;
               q_ctrl.wdata = seed_addr;
               state_in     = S_DEQ;
            end
         end
         S_DEQ: begin
            if (q_stat.empty) begin
               rsp_set  = 1'b1;
               state_in = S_IDLE;
            end else begin
               q_ctrl.pop = 1'b1;
               state_in   = S_CUR;
            end
         end
         S_CUR: begin
            cur_in    = q_stat.rdata;
            pix_re    = 1'b1;
            pix_raddr = q_stat.rdata;
            state_in  = S_PIX;
         end
         S_PIX: begin
            cur_pix_in = pix_rdata_ff;
            dir_in     = DIR_LEFT;
            state_in   = S_NB;
         end
         S_NB: begin
            if (nb_ok) begin
               nb_in    = nb_addr;
               pix_re   = 1'b1;
               lbl_re   = 1'b1;
               state_in = S_EVAL;
            end else begin
               dir_in   = dir_ff + 2'd1;
               state_in = (dir_ff == DIR_UP) ? S_DEQ : S_NB;
            end
         end
         S_EVAL: begin
            if (lbl_rdata_ff == LBL_FREE) begin
               lbl_we = 1'b1;
               if (accept_nb) begin
                  lbl_wdata   = LBL_IN;
                  q_ctrl.push = 1'b1;
               end else begin
                  lbl_wdata = LBL_OUT;
               end
            end
            dir_in   = dir_ff + 2'd1;
            state_in = (dir_ff == DIR_UP) ? S_DEQ : S_NB;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_label_in = rsp_label_ff;
      rsp_done_in  = rsp_done_ff;
      if (rsp_set) begin
         rsp_valid_in = 1'b1;
         rsp_label_in = rsp_set_label;
         rsp_done_in  = rsp_set_done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         dir_ff       <= DIR_LEFT;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         dir_ff       <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      nb_ff        <= nb_in;
      cur_pix_ff   <= cur_pix_in;
      rsp_label_ff <= rsp_label_in;
      rsp_done_ff  <= rsp_done_in;
   end

   always_ff @(posedge clock) begin
      if (pix_we) begin
         pix_mem[req_pixel_index] <= req_pixel_value;
      end
      if (pix_re) begin
         pix_rdata_ff <= pix_mem[pix_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (lbl_we) begin
         lbl_mem[lbl_waddr] <= lbl_wdata;
      end
      if (lbl_re) begin
         lbl_rdata_ff <= lbl_mem[lbl_raddr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_label    = rsp_label_ff;
   assign rsp_done_res = rsp_done_ff;

endmodule

[hw/rtl/threshold_region_growing.sv]
// Top level of the seeded region growing block: register file and instances.
// Depends on trg_pkg, trg_engine and trg_queue.
//
// Usage: words enter on the req_ channel (command, pixel_index, pixel_value)
// and one result word per command leaves on the rsp_ channel (label,
// done_res). Registers are written through the csr_ channel, which is always
// ready; write them only while no command is in flight.
// A load or an unknown command (done_res low) returns its result in the
// cycle after acceptance and, while rsp_ready stays high, can follow every
// cycle; a read answers via S_READ and the next command waits for S_IDLE.
// A grow sweeps the whole label memory, handles the seed in S_GSEED, then
// takes each frontier pixel through S_DEQ, S_CUR and S_PIX and checks its
// neighbors in S_NB, with S_EVAL for each inside the image, as neighbors
// are read and updated one at a time; its result follows in the cycle after
// the frontier runs empty. After reset the block clears the label memory
// with req_ready low; register writes are taken during that time.
// While a result waits on a stalled rsp_ready, req_ready stays low, so one
// command is in the block at a time.
module threshold_region_growing
   import trg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_command,
   input  logic [ADDR_W-1:0]     req_pixel_index,
   input  logic [PIX_W-1:0]      req_pixel_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LBL_W-1:0]      rsp_label,
   output logic                  rsp_done_res,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg_ff, cfg_in;
   q_ctrl_type q_ctrl;
   q_stat_type q_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_WIDTH:     cfg_in.width     = csr_data[SIZE_W-1:0];
            REG_HEIGHT:    cfg_in.height    = csr_data[SIZE_W-1:0];
            REG_SEED_X:    cfg_in.seed_x    = csr_data[COORD_W-1:0];
            REG_SEED_Y:    cfg_in.seed_y    = csr_data[COORD_W-1:0];
            REG_THRESHOLD: cfg_in.threshold = csr_data[THR_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width     <= SIZE_W'(256);
         cfg_ff.height    <= SIZE_W'(256);
         cfg_ff.seed_x    <= '0;
         cfg_ff.seed_y    <= '0;
         cfg_ff.threshold <= THR_W'(16);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   trg_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pixel_index (req_pixel_index),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_label       (rsp_label),
      .rsp_done_res    (rsp_done_res),
      .q_ctrl          (q_ctrl),
      .q_stat          (q_stat)
   );

   trg_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (q_ctrl),
      .stat  (q_stat)
   );

endmodule

[hw/rtl/trg_checker.sv]
// Port checker for the region growing block, bound to the top level.
// Depends on trg_pkg and threshold_region_growing_macros.svh.
`include "threshold_region_growing_macros.svh"

module trg_checker
   import trg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic [CMD_W-1:0]      req_command,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [LBL_W-1:0]      rsp_label,
   input logic                  rsp_done_res
);

   `TRG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result word dropped")
   `TRG_ASSERT_NOW(a_no_accept_full, rsp_valid && !rsp_ready, !req_ready, "accept while full")
   `TRG_ASSERT_NEXT(a_load_rsp, req_valid && req_ready && req_command == CMD_LOAD, rsp_valid && rsp_done_res && rsp_label == LBL_FREE, "bad load result")
   `TRG_ASSERT_NEXT(a_bad_cmd_rsp, req_valid && req_ready && req_command != CMD_LOAD && req_command != CMD_GROW && req_command != CMD_READ, rsp_valid && !rsp_done_res && rsp_label == LBL_FREE, "bad unknown command result")

endmodule

bind threshold_region_growing trg_checker u_trg_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_command  (req_command),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_label    (rsp_label),
   .rsp_done_res (rsp_done_res)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for threshold_region_growing: directed and random command words,
// with every result word compared in order against a behavioral flood-fill label predictor.
// Depends only on trg_pkg and the RTL of the block.
module tb_top;
   import trg_pkg::*;

   localparam logic [CMD_W-1:0]     CMD_SPARE   = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE   = 3'd7;
   localparam int                   HOLD_CYCLES = 300;

   typedef struct packed {
      logic [LBL_W-1:0] label;
      logic             done;
   } result_type;

   class label_scoreboard;
      logic [PIX_W-1:0] gray [DEPTH];
      logic [LBL_W-1:0] marks [DEPTH];
      cfg_type          cfg;
      result_type       awaited [$];
      int               frontier [$];
      int               errors = 0;
      int               checked = 0;
      int               loads = 0;
      int               grows = 0;
      int               reads = 0;
      int               spares = 0;

      function new();
         cfg.width     = 9'd256;
         cfg.height    = 9'd256;
         cfg.seed_x    = 8'd0;
         cfg.seed_y    = 8'd0;
         cfg.threshold = 9'd16;
         foreach (gray[i]) gray[i] = '0;
         foreach (marks[i]) marks[i] = LBL_FREE;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      function int eff_extent(logic [SIZE_W-1:0] v, int limit);
         if (v == 0) return 1;
         if (int'(v) > limit) return limit;
         return int'(v);
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_WIDTH:     cfg.width = data;
            REG_HEIGHT:    cfg.height = data;
            REG_SEED_X:    cfg.seed_x = data[COORD_W-1:0];
            REG_SEED_Y:    cfg.seed_y = data[COORD_W-1:0];
            REG_THRESHOLD: cfg.threshold = data;
            default: ;
         endcase
      endfunction

      function void visit(int cur, int nb);
         int diff;
         if (marks[nb] != LBL_FREE) return;
         diff = int'(gray[cur]) - int'(gray[nb]);
         if (diff < 0) diff = -diff;
         if (diff < int'(cfg.threshold)) begin
            marks[nb] = LBL_IN;
            frontier.insert(frontier.size(), nb);
         end else begin
            marks[nb] = LBL_OUT;
         end
      endfunction

      function void grow_region();
         int w;
         int h;
         int cur;
         int x;
         int y;
         w = eff_extent(cfg.width, MAX_WIDTH);
         h = eff_extent(cfg.height, MAX_HEIGHT);
         foreach (marks[i]) marks[i] = LBL_FREE;
         frontier.delete();
         if (int'(cfg.seed_x) >= w || int'(cfg.seed_y) >= h) return;
         cur = int'(cfg.seed_y) * MAX_WIDTH + int'(cfg.seed_x);
         marks[cur] = LBL_IN;
         frontier.insert(frontier.size(), cur);
         while (frontier.size() > 0) begin
            cur = frontier.pop_front();
            x = cur % MAX_WIDTH;
            y = cur / MAX_WIDTH;
            if (x >= 1) visit(cur, cur - 1);
            if (y + 1 < h) visit(cur, cur + MAX_WIDTH);
            if (x + 1 < w) visit(cur, cur + 1);
            if (y >= 1) visit(cur, cur - MAX_WIDTH);
         end
      endfunction

      function void note_word(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] idx,
                              logic [PIX_W-1:0] val);
         result_type r;
         r.label = LBL_FREE;
         r.done  = 1'b1;
         case (cmd)
            CMD_LOAD: begin
               gray[idx] = val;
               loads++;
            end
            CMD_GROW: begin
               grow_region();
               grows++;
            end
            CMD_READ: begin
               r.label = marks[idx];
               reads++;
            end
            default: begin
               r.done = 1'b0;
               spares++;
            end
         endcase
         awaited.insert(awaited.size(), r);
      endfunction

      function void check_word(logic [LBL_W-1:0] label, logic done);
         result_type want;
         if (awaited.size() == 0) begin
            errors++;
            if (errors <= 100)
               $display("%0t: result word with nothing expected, label %0d done_res %0d",
                        $time, label, done);
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (label !== want.label) begin
            errors++;
            if (errors <= 100)
               $display("%0t: label expected %0d actual %0d", $time, want.label, label);
         end
         if (done !== want.done) begin
            errors++;
            if (errors <= 100)
               $display("%0t: done_res expected %0d actual %0d", $time, want.done, done);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command = CMD_LOAD;
   logic [ADDR_W-1:0]     req_pixel_index = '0;
   logic [PIX_W-1:0]      req_pixel_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [LBL_W-1:0]      rsp_label;
   logic                  rsp_done_res;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = REG_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   label_scoreboard board;
   bit              calm = 1'b0;
   bit              hold_request = 1'b0;
   int              settings = 0;

   threshold_region_growing dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pixel_index (req_pixel_index),
      .req_pixel_value (req_pixel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_label       (rsp_label),
      .rsp_done_res    (rsp_done_res),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] idx,
                            input logic [PIX_W-1:0] val);
      while (!calm && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_pixel_index <= idx;
      req_pixel_value <= val;
      do @(posedge clock); while (!req_ready);
      board.note_word(cmd, idx, val);
   endtask

   task automatic idle_until_empty();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, data);
   endtask

   task automatic apply_geometry(input logic [CSR_DATA_W-1:0] w, h, sx, sy, thr);
      idle_until_empty();
      write_reg(REG_SPARE, CSR_DATA_W'($urandom));
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
      write_reg(REG_SEED_X, sx);
      write_reg(REG_SEED_Y, sy);
      write_reg(REG_THRESHOLD, thr);
      csr_valid <= 1'b0;
      settings++;
   endtask

   task automatic paint_region(input int w, h);
      int base;
      int dx;
      int dy;
      int noise;
      int v;
      base  = $urandom_range(0, 255);
      dx    = int'($urandom_range(0, 12)) - 6;
      dy    = int'($urandom_range(0, 12)) - 6;
      noise = $urandom_range(0, 20);
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            v = base + dx * x + dy * y + int'($urandom_range(0, noise));
            if ($urandom_range(0, 99) < 8) v += 128;
            send_word(CMD_LOAD, ADDR_W'(y * MAX_WIDTH + x), PIX_W'(v));
         end
      end
   endtask

   task automatic mixed_words(input int count, w, h);
      int r;
      int x;
      int y;
      repeat (count) begin
         r = $urandom_range(0, 99);
         x = $urandom_range(0, w - 1);
         y = $urandom_range(0, h - 1);
         if (r < 21) begin
            send_word(CMD_LOAD, ADDR_W'(y * MAX_WIDTH + x), PIX_W'($urandom));
         end else if (r < 30) begin
            send_word(CMD_LOAD, ADDR_W'($urandom), PIX_W'($urandom));
         end else if (r < 75) begin
            send_word(CMD_READ, ADDR_W'(y * MAX_WIDTH + x), PIX_W'($urandom));
         end else if (r < 90) begin
            send_word(CMD_READ, ADDR_W'($urandom), PIX_W'($urandom));
         end else begin
            send_word(CMD_SPARE, ADDR_W'($urandom), PIX_W'($urandom));
         end
      end
   endtask

   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) board.check_word(rsp_label, rsp_done_res);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(0, 99) >= 23;
         end
      end
   end

   initial begin
      #30_000_000;
      $display("tb_top: errors");
      $finish;
   end

   initial begin
      int wr;
      int hr;
      int w;
      int h;
      int sx;
      int sy;
      int thr;
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_word(CMD_READ, '0, '0);
      send_word(CMD_READ, '1, '0);
      send_word(CMD_SPARE, '1, '1);
      send_word(CMD_LOAD, '1, 8'd255);
      send_word(CMD_LOAD, '0, 8'd0);
      apply_geometry(9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
      send_word(CMD_GROW, '0, '0);
      send_word(CMD_READ, 16'd0, '0);
      send_word(CMD_READ, 16'd1, '0);
      apply_geometry(9'd2, 9'd2, 9'd1, 9'd1, 9'd256);
      send_word(CMD_LOAD, 16'd1, 8'd255);
      send_word(CMD_LOAD, 16'd256, 8'd128);
      send_word(CMD_LOAD, 16'd257, 8'd1);
      send_word(CMD_GROW, '1, '1);
      send_word(CMD_READ, 16'd0, '0);
      send_word(CMD_READ, 16'd257, '0);
      send_word(CMD_READ, 16'd2, '0);
      apply_geometry(9'd2, 9'd2, 9'd200, 9'd0, 9'd16);
      send_word(CMD_GROW, '0, '0);
      send_word(CMD_READ, 16'd257, '0);
      apply_geometry(9'd2, 9'd2, 9'd0, 9'd0, 9'd255);
      send_word(CMD_GROW, '0, '0);
      send_word(CMD_READ, 16'd1, '0);
      send_word(CMD_READ, 16'd257, '0);

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: begin
               wr = 511;
               hr = 1;
               sx = $urandom_range(0, 255);
               sy = 0;
            end
            1: begin
               wr = 1;
               hr = 257;
               sx = 0;
               sy = $urandom_range(0, 255);
            end
            default: begin
               wr = ($urandom_range(0, 99) < 12) ? 0 : $urandom_range(1, 12);
               hr = ($urandom_range(0, 99) < 12) ? 0 : $urandom_range(1, 12);
            end
         endcase
         w = board.eff_extent(SIZE_W'(wr), MAX_WIDTH);
         h = board.eff_extent(SIZE_W'(hr), MAX_HEIGHT);
         if (p >= 2) begin
            sx = ($urandom_range(0, 99) < 80) ? $urandom_range(0, w - 1) : $urandom_range(0, 255);
            sy = ($urandom_range(0, 99) < 80) ? $urandom_range(0, h - 1) : $urandom_range(0, 255);
         end
         case ($urandom_range(0, 6))
            0: thr = 0;
            1: thr = 255;
            2: thr = 256;
            3: thr = 511;
            4, 5: thr = $urandom_range(1, 48);
            default: thr = $urandom_range(0, 511);
         endcase
         calm = (p == 1);
         apply_geometry(SIZE_W'(wr), SIZE_W'(hr), {1'($urandom), COORD_W'(sx)},
                        {1'($urandom), COORD_W'(sy)}, THR_W'(thr));
         paint_region(w, h);
         if (p == 2) hold_request = 1'b1;
         mixed_words(50, w, h);
         if (p == 3) idle_until_empty();
         send_word(CMD_GROW, ADDR_W'($urandom), PIX_W'($urandom));
         mixed_words(50, w, h);
      end

      calm = 1'b0;
      idle_until_empty();
      repeat (20) @(posedge clock);
      $display("covered %0d result words: %0d loads, %0d grows, %0d reads, %0d unknown commands",
               board.checked, board.loads, board.grows, board.reads, board.spares);
      $display("under %0d register settings, with %0d mismatches", settings, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
